[rtl/core/gtp_pkg.sv]
package gtp_pkg;

  localparam int CordicSteps = 16;
  localparam int StepW = $clog2(CordicSteps + 1);

  localparam logic signed [19:0] PiQ16     = 20'sd205887;
  localparam logic signed [19:0] TwoPiQ16  = 20'sd411775;
  localparam logic signed [19:0] HalfPiQ16 = 20'sd102944;
  localparam logic signed [33:0] PiQ30     = 34'sd3373259426;
  localparam logic [27:0] InvKQ28 = 28'd163008219;

  localparam logic [2:0] PhIdle    = 3'd0;
  localparam logic [2:0] PhRotHead = 3'd1;
  localparam logic [2:0] PhTrans   = 3'd2;
  localparam logic [2:0] PhRotGoal = 3'd3;
  localparam logic [2:0] PhReached = 3'd4;

  localparam logic [2:0] RegLinGain  = 3'd0;
  localparam logic [2:0] RegAngGain  = 3'd1;
  localparam logic [2:0] RegDistTol  = 3'd2;
  localparam logic [2:0] RegAngTol   = 3'd3;
  localparam logic [2:0] RegStopSpd  = 3'd4;
  localparam logic [2:0] RegSteerDst = 3'd5;

  // atan(2^-k) in Q2.30
  function automatic logic signed [33:0] atan_entry(input logic [4:0] k);
    logic signed [33:0] r;
    begin
      case (k)
        5'd0: r = 34'sd843314857;
        5'd1: r = 34'sd497837829;
        5'd2: r = 34'sd263043837;
        5'd3: r = 34'sd133525159;
        5'd4: r = 34'sd67021687;
        5'd5: r = 34'sd33543516;
        5'd6: r = 34'sd16775851;
        5'd7: r = 34'sd8388437;
        5'd8: r = 34'sd4194283;
        5'd9: r = 34'sd2097149;
        default: r = 34'(64'sd1073741824 >>> k);
      endcase
      return r;
    end
  endfunction

endpackage

[rtl/core/gtp_cordic.sv]
module gtp_cordic
  import gtp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [32:0] dx_i,
  input  logic signed [32:0] dy_i,
  output logic               done_o,
  output logic signed [19:0] ang_o,
  output logic        [33:0] mag_o
);

  typedef enum logic [1:0] {CIdle, CRun, CScale, CDone} cst_e;

  cst_e               st_q;
  logic [StepW-1:0]   k_q;
  logic signed [51:0] x_q, y_q;
  logic signed [33:0] z_q;
  logic signed [19:0] ang_q;
  logic        [33:0] mag_q;

  logic signed [51:0] xs, ys, xin, yin;
  logic [4:0]         kk;
  logic [63:0]        prod;

  assign kk   = 5'(k_q);
  assign xs   = x_q >>> kk;
  assign ys   = y_q >>> kk;
  assign xin  = 52'(dx_i) <<< 16;
  assign yin  = 52'(dy_i) <<< 16;
  assign prod = 64'(x_q[51:14]) * 64'(InvKQ28) + (64'(1) << 29);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= CIdle;
      k_q  <= '0;
    end else begin
      case (st_q)
        CIdle: begin
          if (start_i) begin
            k_q <= '0;
            if (dx_i == 0 && dy_i == 0) begin
              ang_q <= '0;
              mag_q <= '0;
              st_q  <= CDone;
            end else begin
              if (dx_i < 0) begin
                x_q <= -xin;
                y_q <= -yin;
                z_q <= (dy_i >= 0) ? PiQ30 : -PiQ30;
              end else begin
                x_q <= xin;
                y_q <= yin;
                z_q <= '0;
              end
              st_q <= CRun;
            end
          end
        end
        CRun: begin
          if (y_q >= 0) begin
            x_q <= x_q + ys;
            y_q <= y_q - xs;
            z_q <= z_q + atan_entry(kk);
          end else begin
            x_q <= x_q - ys;
            y_q <= y_q + xs;
            z_q <= z_q - atan_entry(kk);
          end
          if (k_q == StepW'(CordicSteps - 1)) st_q <= CScale;
          k_q <= k_q + 1'b1;
        end
        CScale: begin
          ang_q <= 20'((z_q + 34'sd8192) >>> 14);
          mag_q <= prod[63:30];
          st_q  <= CDone;
        end
        CDone: st_q <= CIdle;
        default: st_q <= CIdle;
      endcase
    end
  end

  assign done_o = (st_q == CDone);
  assign ang_o  = ang_q;
  assign mag_o  = mag_q;

  a_k_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == CRun |-> k_q < StepW'(CordicSteps)) else $error("cordic step overrun");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done not a pulse");
  a_scale_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == CScale |=> done_o) else $error("scale without done");

endmodule

[rtl/core/go_to_pose_controller_core.sv]
// Go-to-pose controller (rotate, translate, rotate).
// Input stream s_axis: tuser = command (0 set goal, 1 control tick),
// tdata = goal and pose fields. A set-goal beat is stored only in phase
// idle and gives no result. Each tick gives one m_axis beat with the
// linear and angular commands and the phase after the step.
// A tick passes the CORDIC (start, rotations, scaling), two gain
// products and the phase decision before its result is shown; the
// CORDIC skips rotations and scaling when pose and goal coincide. The
// shared CORDIC iterates one rotation per cycle and a 21x35 gain product
// is formed once per cycle, twice per tick. A set-goal beat leaves the
// block idle. One item is in work at a time; s_axis_tready is low while
// an item is in work or a result waits.
// If the receiver stalls, the result holds on m_axis and no new item is
// taken. Reset clears the phase to idle, the goal to zero and loads the
// register defaults. cfg writes (index 0..5) land at any edge with
// cfg_we_i high and must only be done while idle.
module go_to_pose_controller_core
  import gtp_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [20:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // goal_x, goal_y, goal_heading, pose_x, pose_y, pose_heading,
  // measured_lin_vel, measured_ang_vel (232 bits used)
  input  logic [231:0] s_axis_tdata,
  input  logic         s_axis_tuser,   // command
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // lin_vel_cmd, ang_vel_cmd, phase, zero pad
  output logic [71:0]  m_axis_tdata
);

  typedef enum logic [2:0] {SIdle, SCord, SMul, SSat, SOut} st_e;

  st_e st_q;
  logic [2:0]  phase_q;
  logic [2:0]  phase_d;
  logic signed [31:0] gx_q, gy_q;
  logic signed [19:0] gh_q;
  logic signed [19:0] ph_q;
  logic signed [31:0] v_q, w_q;
  logic [20:0] lin_gain_q, ang_gain_q, dist_tol_q, stop_q, steer_q;
  logic [17:0] ang_tol_q;
  logic signed [33:0] he_q, te_q;
  logic signed [19:0] hdg_q;
  logic [33:0] dist_q;
  logic mstep_q;
  logic signed [31:0] lin_q, ang_q;
  logic signed [31:0] lin_r, ang_r;
  logic [2:0] ph_out_q;

  logic signed [32:0] dx, dy;
  logic cdone;
  logic signed [19:0] cang;
  logic [33:0] cmag;

  logic signed [31:0] px, py;
  assign px = s_axis_tdata[115:84];
  assign py = s_axis_tdata[147:116];

  logic signed [31:0] pxs_q, pys_q;
  assign dx = 33'(gx_q) - 33'(pxs_q);
  assign dy = 33'(gy_q) - 33'(pys_q);

  logic cstart_q;

  gtp_cordic u_cordic (
    .clk_i, .rst_ni, .start_i(cstart_q), .dx_i(dx), .dy_i(dy),
    .done_o(cdone), .ang_o(cang), .mag_o(cmag)
  );

  function automatic logic signed [33:0] wrap(input logic signed [33:0] e);
    logic signed [33:0] r;
    begin
      r = e;
      if (r > 34'(PiQ16)) r = r - 34'(TwoPiQ16);
      if (r > 34'(PiQ16)) r = r - 34'(TwoPiQ16);
      if (r > 34'(PiQ16)) r = r - 34'(TwoPiQ16);
      if (r < -34'(PiQ16)) r = r + 34'(TwoPiQ16);
      if (r < -34'(PiQ16)) r = r + 34'(TwoPiQ16);
      if (r < -34'(PiQ16)) r = r + 34'(TwoPiQ16);
      return r;
    end
  endfunction

  function automatic logic signed [31:0] sat(input logic signed [65:0] p);
    logic signed [65:0] q;
    begin
      q = (p + 66'sd32768) >>> 16;
      if (q > 66'sd2147483647) return 32'sh7fffffff;
      if (q < -66'sd2147483648) return 32'sh80000000;
      return 32'(q);
    end
  endfunction

  // shared multiplier: gain x operand, one product per cycle
  logic [20:0] mg;
  logic signed [34:0] mo;
  logic signed [65:0] mp;
  always_comb begin
    if (!mstep_q) begin
      mg = lin_gain_q;
      mo = 35'($signed({1'b0, dist_q}));
    end else begin
      mg = ang_gain_q;
      mo = (phase_q == PhRotGoal) ? 35'(te_q) : 35'(he_q);
    end
    mp = 66'($signed({1'b0, mg})) * 66'(mo);
  end

  logic [33:0] ahe, ate;
  logic [31:0] av, aw;
  logic [19:0] ahd;
  assign ahe = he_q[33] ? 34'(-he_q) : 34'(he_q);
  assign ate = te_q[33] ? 34'(-te_q) : 34'(te_q);
  assign av  = v_q[31] ? 32'(-v_q) : 32'(v_q);
  assign aw  = w_q[31] ? 32'(-w_q) : 32'(w_q);
  assign ahd = hdg_q[19] ? 20'(-hdg_q) : 20'(hdg_q);
  // abs of INT_MIN as unsigned 2^31 is correct when compared unsigned
  logic w_le, w_lt, v_lt;
  assign w_le = {1'b0, aw} <= 33'(stop_q);
  assign w_lt = 33'(aw) < 33'(stop_q);
  assign v_lt = 33'(av) < 33'(stop_q);

  always_comb begin
    lin_r = 32'sd0;
    ang_r = 32'sd0;
    phase_d = phase_q;
    case (phase_q)
      PhRotHead: begin
        ang_r = ang_q;
        if (ahe < 34'(ang_tol_q) && w_le) begin
          phase_d = PhTrans; ang_r = 32'sd0;
        end
      end
      PhTrans: begin
        lin_r = lin_q;
        if (ahd > 20'(HalfPiQ16))
          lin_r = (lin_q == 32'sh80000000) ? 32'sh7fffffff : -lin_q;
        if (dist_q > 34'(steer_q)) ang_r = ang_q;
        if (dist_q <= 34'(dist_tol_q) && v_lt && w_lt) begin
          phase_d = PhRotGoal; lin_r = 32'sd0; ang_r = 32'sd0;
        end
      end
      PhRotGoal: begin
        ang_r = ang_q;
        if (ate < 34'(ang_tol_q) && w_le) begin
          phase_d = PhReached; ang_r = 32'sd0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle;
      phase_q <= PhIdle;
      gx_q <= '0; gy_q <= '0; gh_q <= '0;
      lin_gain_q <= 21'd78643;
      ang_gain_q <= 21'd65536;
      dist_tol_q <= 21'd3277;
      ang_tol_q  <= 18'd1144;
      stop_q     <= 21'd655;
      steer_q    <= 21'd13107;
      cstart_q   <= 1'b0;
      mstep_q    <= 1'b0;
    end else begin
      cstart_q <= 1'b0;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegLinGain:  lin_gain_q <= cfg_data_i;
          RegAngGain:  ang_gain_q <= cfg_data_i;
          RegDistTol:  dist_tol_q <= cfg_data_i;
          RegAngTol:   ang_tol_q  <= cfg_data_i[17:0];
          RegStopSpd:  stop_q     <= cfg_data_i;
          RegSteerDst: steer_q    <= cfg_data_i;
          default: ;
        endcase
      end
      case (st_q)
        SIdle: begin
          if (s_axis_tvalid) begin
            if (!s_axis_tuser) begin
              if (phase_q == PhIdle) begin
                gx_q <= s_axis_tdata[31:0];
                gy_q <= s_axis_tdata[63:32];
                gh_q <= s_axis_tdata[83:64];
                phase_q <= PhRotHead;
              end
            end else begin
              pxs_q <= px; pys_q <= py;
              ph_q <= s_axis_tdata[167:148];
              v_q  <= s_axis_tdata[199:168];
              w_q  <= s_axis_tdata[231:200];
              cstart_q <= 1'b1;
              st_q <= SCord;
            end
          end
        end
        SCord: begin
          if (cdone) begin
            hdg_q  <= cang;
            dist_q <= cmag;
            he_q <= wrap(34'(cang) - 34'(ph_q));
            te_q <= wrap(34'(gh_q) - 34'(ph_q));
            mstep_q <= 1'b0;
            st_q <= SMul;
          end
        end
        SMul: begin
          if (!mstep_q) begin
            lin_q <= sat(mp);
            mstep_q <= 1'b1;
          end else begin
            ang_q <= sat(mp);
            st_q <= SSat;
          end
        end
        SSat: begin
          phase_q <= phase_d;
          lin_q <= lin_r;
          ang_q <= ang_r;
          st_q <= SOut;
        end
        SOut: if (m_axis_tready) st_q <= SIdle;
        default: st_q <= SIdle;
      endcase
    end
  end

  // phase reported after the step is the registered phase once in SOut
  assign ph_out_q = phase_q;
  assign s_axis_tready = (st_q == SIdle);
  assign m_axis_tvalid = (st_q == SOut);
  assign m_axis_tdata  = {5'd0, ph_out_q, ang_q, lin_q};

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("ready while result pending");
  a_reached: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(phase_q) == PhReached |-> phase_q == PhReached) else $error("left reached");

endmodule

[sim/go_to_pose_controller_core_tb.sv]
module go_to_pose_controller_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gtp_pkg::*;

  localparam logic [2:0] RegUnused = 3'd6;
  localparam int CycleLimit = 600000;
  localparam longint IntMax = 64'sd2147483647;
  localparam longint IntMin = -64'sd2147483648;
  localparam longint HeadMax = 411775;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [2:0]   cfg_idx_i = '0;
  logic [20:0]  cfg_data_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [231:0] s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [71:0]  m_axis_tdata;

  go_to_pose_controller_core dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  typedef struct {
    logic signed [31:0] lin;
    logic signed [31:0] ang;
    logic [2:0]         ph;
  } drive_cmd_t;

  typedef struct {
    bit     cmd;
    longint gx, gy, gh, px, py, phd, v, w;
    bit     typed;
    longint e_lin, e_ang;
    logic [2:0] e_ph;
  } stim_row_t;

  drive_cmd_t expected_cmds[$];
  int errors = 0;
  int n_items = 0;
  int n_results = 0;
  int n_reached_ticks = 0;
  bit hold_rx = 1'b0;
  bit quiet = 1'b0;

  // controller state as predicted
  logic [2:0] mp;
  longint goal_x, goal_y, goal_h;
  longint lin_gain, ang_gain, dist_tol, ang_tol, stop_spd, steer_dst;

  longint atan_tab[10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                           33543516, 16775851, 8388437, 4194283, 2097149};

  function automatic longint clamp32(longint v);
    return (v > IntMax) ? IntMax : (v < IntMin) ? IntMin : v;
  endfunction

  function automatic longint absl(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint spread(int a);
    return longint'($urandom_range(2 * a)) - a;
  endfunction

  function automatic longint rand_heading();
    return longint'($urandom_range(2 * HeadMax)) - HeadMax;
  endfunction

  function automatic longint rand32();
    return longint'($signed($urandom));
  endfunction

  function automatic void polar(input longint dx, input longint dy,
                                output longint ang, output longint mag);
    longint x, y, z, xs, ys, step;
    longint unsigned ux;
    z = 0;
    if (dx == 0 && dy == 0) begin
      ang = 0;
      mag = 0;
      return;
    end
    x = dx * 65536;
    y = dy * 65536;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = (dy >= 0) ? longint'(PiQ30) : -longint'(PiQ30);
    end
    for (int k = 0; k < CordicSteps; k++) begin
      xs = x >>> k;
      ys = y >>> k;
      step = (k < 10) ? atan_tab[k] : (64'sd1073741824 >>> k);
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + step;
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - step;
      end
    end
    ang = (z + 8192) >>> 14;
    ux = longint'(x);
    mag = longint'((((ux >> 14) * longint'(InvKQ28)) + (64'd1 << 29)) >> 30);
  endfunction

  function automatic longint wrap_err(longint e);
    while (e > PiQ16) e = e - TwoPiQ16;
    while (e < -PiQ16) e = e + TwoPiQ16;
    return e;
  endfunction

  function automatic longint gain_times(longint g, longint v);
    return clamp32((g * v + 32768) >>> 16);
  endfunction

  function automatic bit advance_controller(input stim_row_t r, output drive_cmd_t c);
    longint hd, dst_len, herr, terr, lin, ang;
    lin = 0;
    ang = 0;
    if (!r.cmd) begin
      if (mp == PhIdle) begin
        goal_x = r.gx;
        goal_y = r.gy;
        goal_h = r.gh;
        mp = PhRotHead;
      end
      return 1'b0;
    end
    polar(goal_x - r.px, goal_y - r.py, hd, dst_len);
    herr = wrap_err(hd - r.phd);
    terr = wrap_err(goal_h - r.phd);
    case (mp)
      PhRotHead: begin
        ang = gain_times(ang_gain, herr);
        if (absl(herr) < ang_tol && absl(r.w) <= stop_spd) begin
          mp = PhTrans;
          ang = 0;
        end
      end
      PhTrans: begin
        lin = gain_times(lin_gain, dst_len);
        if (absl(hd) > HalfPiQ16) lin = clamp32(-lin);
        if (dst_len > steer_dst) ang = gain_times(ang_gain, herr);
        if (dst_len <= dist_tol && absl(r.v) < stop_spd && absl(r.w) < stop_spd) begin
          mp = PhRotGoal;
          lin = 0;
          ang = 0;
        end
      end
      PhRotGoal: begin
        ang = gain_times(ang_gain, terr);
        if (absl(terr) < ang_tol && absl(r.w) <= stop_spd) begin
          mp = PhReached;
          ang = 0;
        end
      end
      default: ;
    endcase
    c.lin = lin[31:0];
    c.ang = ang[31:0];
    c.ph = mp;
    return 1'b1;
  endfunction

  task automatic write_reg(logic [2:0] idx, longint val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val[20:0];
    case (idx)
      RegLinGain:  lin_gain = val & 64'h1FFFFF;
      RegAngGain:  ang_gain = val & 64'h1FFFFF;
      RegDistTol:  dist_tol = val & 64'h1FFFFF;
      RegAngTol:   ang_tol = val & 64'h3FFFF;
      RegStopSpd:  stop_spd = val & 64'h1FFFFF;
      RegSteerDst: steer_dst = val & 64'h1FFFFF;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic load_settings(longint lg, longint ag, longint dt, longint at,
                               longint ss, longint sd);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    wait (expected_cmds.size() == 0);
    repeat (30) @(posedge clk_i);
    write_reg(RegLinGain, lg);
    write_reg(RegAngGain, ag);
    write_reg(RegDistTol, dt);
    write_reg(RegAngTol, at);
    write_reg(RegStopSpd, ss);
    write_reg(RegSteerDst, sd);
    write_reg(RegUnused, 64'h1FFFFF);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_beat(stim_row_t r);
    drive_cmd_t c;
    logic [19:0] gh20, ph20;
    gh20 = r.gh[19:0];
    ph20 = r.phd[19:0];
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= r.cmd;
    s_axis_tdata <= {r.w[31:0], r.v[31:0], ph20, r.py[31:0], r.px[31:0],
                     gh20, r.gy[31:0], r.gx[31:0]};
    do @(posedge clk_i); while (!s_axis_tready);
    n_items++;
    if (advance_controller(r, c)) begin
      if (r.typed) begin
        c.lin = r.e_lin[31:0];
        c.ang = r.e_ang[31:0];
        c.ph = r.e_ph;
      end
      expected_cmds.push_back(c);
    end
    if (!quiet && $urandom_range(99) < 13) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    drive_cmd_t e;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        n_results++;
        if (expected_cmds.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected: %h", $time, m_axis_tdata);
        end else begin
          e = expected_cmds.pop_front();
          if (e.ph == PhReached) n_reached_ticks++;
          if (m_axis_tdata[31:0] !== e.lin || m_axis_tdata[63:32] !== e.ang ||
              m_axis_tdata[66:64] !== e.ph) begin
            errors++;
            $display("%0t: mismatch lin/ang/phase expected %0d %0d %0d actual %0d %0d %0d",
                     $time, e.lin, e.ang, e.ph, $signed(m_axis_tdata[31:0]),
                     $signed(m_axis_tdata[63:32]), m_axis_tdata[66:64]);
          end
        end
      end
      m_axis_tready <= !hold_rx && (quiet || $urandom_range(99) >= 13);
    end
  end

  // long receiver stall so the input side backs up
  initial begin
    wait (n_items >= 150);
    @(posedge clk_i);
    hold_rx <= 1'b1;
    repeat (300) @(posedge clk_i);
    hold_rx <= 1'b0;
  end

  always @(posedge clk_i) quiet <= (n_items >= 250 && n_items < 330);

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("go_to_pose_controller_core_tb: FAIL");
    $finish;
  end

  initial begin
    stim_row_t rows[$];
    stim_row_t r;
    longint hd, dm;
    int hit_pct[5] = '{0, 4, 4, 8, 25};
    longint seg_cfg[5][6] = '{
      '{0, 0, 0, 0, 0, 0},
      '{78643, 65536, 3277, 1144, 655, 13107},
      '{0, 0, 0, 0, 0, 0},
      '{1048576, 1048576, 1048576, 205887, 1048576, 1048576},
      '{78643, 65536, 3277, 1144, 655, 13107}};
    mp = PhIdle;
    goal_x = 0;
    goal_y = 0;
    goal_h = 0;
    lin_gain = 78643;
    ang_gain = 65536;
    dist_tol = 3277;
    ang_tol = 1144;
    stop_spd = 655;
    steer_dst = 13107;
    seg_cfg[2] = '{$urandom_range(1048576), $urandom_range(1048576),
                   $urandom_range(1048576), $urandom_range(205887),
                   $urandom_range(1048576), $urandom_range(1048576)};

    rows = '{
      '{1, 0, 0, 0, IntMax, IntMax, HeadMax, IntMax, IntMax, 1, 0, 0, PhIdle},
      '{1, 0, 0, 0, IntMin, IntMin, -HeadMax, IntMin, IntMin, 1, 0, 0, PhIdle},
      '{0, IntMax, IntMin, HeadMax, 0, 0, 0, 0, 0, 0, 0, 0, PhIdle},
      '{1, 0, 0, 0, IntMin, IntMax, -HeadMax, IntMin, IntMax, 0, 0, 0, PhIdle},
      '{1, 0, 0, 0, IntMax, IntMin, 0, 0, IntMax, 0, 0, 0, PhIdle},
      '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, PhIdle},
      '{1, 0, 0, 0, 0, 0, PiQ16, 0, IntMin, 0, 0, 0, PhIdle},
      '{1, 0, 0, 0, IntMax, 0, HeadMax, 0, 100000, 0, 0, 0, PhIdle},
      '{1, 0, 0, 0, IntMin, IntMin, -PiQ16, 0, -100000, 0, 0, 0, PhIdle},
      '{1, 0, 0, 0, IntMax - 1, IntMin + 1, -1, -1, 1, 0, 0, 0, PhIdle}};

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send_beat(rows[i]);

    for (int s = 0; s < 5; s++) begin
      load_settings(seg_cfg[s][0], seg_cfg[s][1], seg_cfg[s][2], seg_cfg[s][3],
                    seg_cfg[s][4], seg_cfg[s][5]);
      for (int i = 0; i < 90; i++) begin
        r = '{default: 0};
        r.cmd = ($urandom_range(99) >= 12);
        r.gx = ($urandom_range(1)) ? rand32() : spread(1 << 20);
        r.gy = ($urandom_range(1)) ? rand32() : spread(1 << 20);
        r.gh = rand_heading();
        r.px = clamp32(goal_x - spread(1 << 20));
        r.py = clamp32(goal_y - spread(1 << 20));
        r.phd = rand_heading();
        r.v = spread(2000);
        r.w = spread(2000);
        if ($urandom_range(99) < 10) begin
          r.px = rand32();
          r.py = rand32();
          r.v = rand32();
          r.w = rand32();
        end else if ($urandom_range(99) < hit_pct[s]) begin
          case (mp)
            PhRotHead: begin
              polar(goal_x - r.px, goal_y - r.py, hd, dm);
              r.phd = hd + spread(300);
              r.w = spread(200);
            end
            PhTrans: begin
              r.px = clamp32(goal_x + spread(100));
              r.py = clamp32(goal_y + spread(100));
              r.v = spread(200);
              r.w = spread(200);
            end
            PhRotGoal: begin
              r.phd = goal_h + spread(300);
              if (r.phd > HeadMax) r.phd = HeadMax;
              if (r.phd < -HeadMax) r.phd = -HeadMax;
              r.w = spread(200);
            end
            default: ;
          endcase
        end
        send_beat(r);
      end
    end

    s_axis_tvalid <= 1'b0;
    wait (expected_cmds.size() == 0);
    repeat (40) @(posedge clk_i);
    if (expected_cmds.size() != 0) errors++;
    $display("Sent %0d beats over five register settings, checked %0d results,",
             n_items, n_results);
    $display("final phase %0d, %0d ticks in goal-reached, %0d errors.",
             mp, n_reached_ticks, errors);
    if (errors == 0) begin
      $display("go_to_pose_controller_core_tb: PASS");
    end else begin
      $display("go_to_pose_controller_core_tb: FAIL");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/gtp_pkg.sv
rtl/core/gtp_cordic.sv
rtl/core/go_to_pose_controller_core.sv
sim/go_to_pose_controller_core_tb.sv
